[rtl/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
// Depends on nothing; users must provide clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising edge outside reset.
`define HSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds at a rising edge outside reset.
`define HSA_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

[rtl/hsa_pkg.sv]
// Shared types and constants of the hinted slot allocator.
// Depends on nothing; used by every module of the block.
package hsa_pkg;

  localparam int unsigned SLOTS   = 64;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned HINT_W  = 32;
  localparam int unsigned ITER_W  = 5;

  localparam logic [COUNT_W-1:0] COUNT_MIN   = 7'd2;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd64;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

  localparam logic OP_PICK    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic                     op;
    logic                     has_hint;
    logic signed [HINT_W-1:0] hint_value;
    logic        [SLOT_W-1:0] release_slot;
  } in_word_t;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] slot_index;
  } out_word_t;

  // Start request to the modulo unit.
  typedef struct packed {
    logic              start;
    logic              neg;
    logic [HINT_W-1:0] mag;
    logic [SLOT_W-1:0] divisor;
  } div_req_t;

  // Floor modulo result, valid in the cycle done is high.
  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] modulo;
  } div_rsp_t;

  // Write to the busy map.
  typedef struct packed {
    logic              we;
    logic              busy;
    logic [SLOT_W-1:0] idx;
  } busy_cmd_t;

endpackage

[rtl/hinted_slot_allocator_core.sv]
// Top level of the hinted slot allocator: sequencer, count register, result register.
// Depends on hsa_pkg, hsa_mod_unit, hsa_busy_map and assert_macros.svh.
//
// Usage: requests arrive as one word on the in channel (valid/ready) and each
// produces exactly one result word on the out channel (valid/ready). The
// slot_count register is written through cfg_we_i/cfg_data_i; the user must
// write it only while idle, as the block itself does not enforce this. A release
// goes from idle through ST_OUT into the output register. A hinted pick runs the
// floor modulo through a bit-serial remainder unit, one dividend bit per cycle,
// then checks the hinted slot in ST_CHECK. A pick without a hint scans the busy
// map one slot per cycle from slot 0. The input is ready again in the cycle the
// result turns valid, and one request is in work at a time.
// Reset clears every busy mark at once and sets slot_count to 64; the block is
// ready as soon as reset is released. When the receiver stalls, the result
// word is held in the output register and the next request can still be
// accepted; its result waits in the sequencer until the register drains.
`include "assert_macros.svh"
module hinted_slot_allocator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  hsa_pkg::in_word_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output hsa_pkg::out_word_t          out_data_o,
  input  logic                        cfg_we_i,
  input  logic [hsa_pkg::COUNT_W-1:0] cfg_data_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [hsa_pkg::COUNT_W-1:0] count_q;
  logic [hsa_pkg::COUNT_W-1:0] cnt;
  logic [hsa_pkg::SLOT_W-1:0]  last_slot;
  logic [hsa_pkg::SLOT_W-1:0]  work_idx_q, work_idx_d;
  logic [hsa_pkg::COUNT_W-1:0] work_idx_ext;
  hsa_pkg::out_word_t          res_q, res_d;
  hsa_pkg::out_word_t          out_q, out_d;
  logic                        out_valid_q, out_valid_d;
  logic                        in_fire;
  logic                        rd_busy;
  hsa_pkg::div_req_t           div_req;
  hsa_pkg::div_rsp_t           div_rsp;
  hsa_pkg::busy_cmd_t          busy_cmd;

  // Effective pool size, clamped into the legal range.
  always_comb begin
    if (count_q < hsa_pkg::COUNT_MIN) begin
      cnt = hsa_pkg::COUNT_MIN;
    end else if (count_q > hsa_pkg::COUNT_MAX) begin
      cnt = hsa_pkg::COUNT_MAX;
    end else begin
      cnt = count_q;
    end
  end

  assign last_slot    = hsa_pkg::SLOT_W'(cnt - 1'b1);
  assign work_idx_ext = {1'b0, work_idx_q};
  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;

  always_comb begin
    div_req.start   = 1'b0;
    div_req.neg     = in_data_i.hint_value[hsa_pkg::HINT_W-1];
    div_req.mag     = in_data_i.hint_value[hsa_pkg::HINT_W-1]
                      ? (~in_data_i.hint_value + 1'b1) : in_data_i.hint_value;
    div_req.divisor = last_slot;
    busy_cmd        = '0;
    state_d         = state_q;
    work_idx_d      = work_idx_q;
    res_d           = res_q;
    out_d           = out_q;
    out_valid_d     = out_valid_q && !out_ready_i;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data_i.op == hsa_pkg::OP_RELEASE) begin
            if ({1'b0, in_data_i.release_slot} < cnt) begin
              busy_cmd.we   = 1'b1;
              busy_cmd.busy = 1'b0;
              busy_cmd.idx  = in_data_i.release_slot;
              res_d.granted    = 1'b1;
              res_d.slot_index = in_data_i.release_slot;
            end else begin
              res_d = '0;
            end
            state_d = ST_OUT;
          end else if (in_data_i.has_hint) begin
            div_req.start = 1'b1;
            state_d       = ST_DIV;
          end else begin
            work_idx_d = '0;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          // Hinted slots live in 1..count-1; the modulo is at most 62.
          work_idx_d = div_rsp.modulo + 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!rd_busy) begin
          busy_cmd.we      = 1'b1;
          busy_cmd.busy    = 1'b1;
          busy_cmd.idx     = work_idx_q;
          res_d.granted    = 1'b1;
          res_d.slot_index = work_idx_q;
        end else begin
          res_d = '0;
        end
        state_d = ST_OUT;
      end
      ST_SCAN: begin
        if (!rd_busy) begin
          busy_cmd.we      = 1'b1;
          busy_cmd.busy    = 1'b1;
          busy_cmd.idx     = work_idx_q;
          res_d.granted    = 1'b1;
          res_d.slot_index = work_idx_q;
          state_d          = ST_OUT;
        end else if (work_idx_q == last_slot) begin
          res_d   = '0;
          state_d = ST_OUT;
        end else begin
          work_idx_d = work_idx_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= hsa_pkg::COUNT_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    work_idx_q <= work_idx_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  hsa_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  hsa_busy_map u_busy (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (busy_cmd),
    .rd_idx_i  (work_idx_q),
    .rd_busy_o (rd_busy)
  );

  `HSA_ASSERT(a_div_done_in_div, div_rsp.done |-> state_q == ST_DIV, "modulo done outside wait")
  `HSA_ASSERT(a_scan_in_pool, state_q == ST_SCAN |-> work_idx_ext < cnt, "scan past pool end")
  `HSA_NEVER(a_hint_slot_zero, state_q == ST_CHECK && work_idx_q == '0, "hint mapped to slot 0")
  `HSA_NEVER(a_refusal_index, out_valid_o && !out_data_o.granted && out_data_o.slot_index != '0,
             "refusal with nonzero index")

endmodule

[rtl/hsa_mod_unit.sv]
// Iterative floor modulo of a 32-bit signed value by a 6-bit divisor.
// One restoring subtract step per cycle; depends on hsa_pkg.
module hsa_mod_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hsa_pkg::div_req_t req_i,
  output hsa_pkg::div_rsp_t rsp_o
);

  logic                       active_q, active_d;
  logic                       done_q, done_d;
  logic [hsa_pkg::ITER_W-1:0] iter_q, iter_d;
  logic [hsa_pkg::HINT_W-1:0] mag_q, mag_d;
  logic [hsa_pkg::SLOT_W-1:0] rem_q, rem_d;
  logic [hsa_pkg::SLOT_W-1:0] div_q, div_d;
  logic                       neg_q, neg_d;
  logic [hsa_pkg::SLOT_W:0]   trial;

  // The partial remainder stays below the divisor, so one shifted bit fits in 7 bits.
  assign trial = {rem_q, mag_q[hsa_pkg::HINT_W-1]};

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    iter_d   = iter_q;
    mag_d    = mag_q;
    rem_d    = rem_q;
    div_d    = div_q;
    neg_d    = neg_q;
    if (req_i.start) begin
      active_d = 1'b1;
      iter_d   = '1;
      mag_d    = req_i.mag;
      rem_d    = '0;
      div_d    = req_i.divisor;
      neg_d    = req_i.neg;
    end else if (active_q) begin
      mag_d = {mag_q[hsa_pkg::HINT_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = hsa_pkg::SLOT_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[hsa_pkg::SLOT_W-1:0];
      end
      iter_d = iter_q - 1'b1;
      if (iter_q == '0) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q <= iter_d;
    mag_q  <= mag_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    neg_q  <= neg_d;
  end

  // A negative dividend with a nonzero remainder wraps up to the floor result.
  assign rsp_o.done   = done_q;
  assign rsp_o.modulo = (neg_q && (rem_q != '0)) ? (div_q - rem_q) : rem_q;

endmodule

[rtl/hsa_busy_map.sv]
// Busy mark per slot, cleared at reset, with one read and one write port.
// Depends on hsa_pkg.
module hsa_busy_map (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  hsa_pkg::busy_cmd_t         cmd_i,
  input  logic [hsa_pkg::SLOT_W-1:0] rd_idx_i,
  output logic                       rd_busy_o
);

  logic [hsa_pkg::SLOTS-1:0] busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else if (cmd_i.we) begin
      busy_q[cmd_i.idx] <= cmd_i.busy;
    end
  end

  assign rd_busy_o = busy_q[rd_idx_i];

endmodule

[verif/hinted_slot_allocator_core_test.sv]
// Self-checking testbench of hinted_slot_allocator_core: picks and releases
// go in as words and each result word is checked against a slot-map model.
// Depends on hsa_pkg and the allocator RTL.
module hinted_slot_allocator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 800000;
  localparam int unsigned HOLD_CYCLES  = 400;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid;
  logic                        in_ready;
  hsa_pkg::in_word_t           in_data;
  logic                        out_valid;
  logic                        out_ready;
  hsa_pkg::out_word_t          out_data;
  logic                        cfg_we;
  logic [hsa_pkg::COUNT_W-1:0] cfg_data;

  // Model of the pool.
  logic                        busy_mark [hsa_pkg::SLOTS];
  logic [hsa_pkg::COUNT_W-1:0] pool_count;
  hsa_pkg::out_word_t          owed_results [$];

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned hold_off_cycles;
  int unsigned stall_left;
  bit          calm;

  hinted_slot_allocator_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned effective_count();
    int unsigned c;
    c = pool_count;
    if (c < hsa_pkg::COUNT_MIN) c = hsa_pkg::COUNT_MIN;
    if (c > hsa_pkg::COUNT_MAX) c = hsa_pkg::COUNT_MAX;
    return c;
  endfunction

  // Applies one request to the model and returns the result word it causes.
  function automatic hsa_pkg::out_word_t allocate_or_free(hsa_pkg::in_word_t w);
    hsa_pkg::out_word_t res;
    int unsigned        cnt;
    int unsigned        i;
    longint             h;
    longint             n;
    longint             r;
    cnt = effective_count();
    res = '0;
    if (w.op == hsa_pkg::OP_RELEASE) begin
      if (w.release_slot < cnt) begin
        busy_mark[w.release_slot] = 1'b0;
        res.granted    = 1'b1;
        res.slot_index = w.release_slot;
      end
      return res;
    end
    if (w.has_hint) begin
      h = longint'($signed(w.hint_value));
      n = longint'(cnt) - 1;
      // Floor modulo: the remainder takes the sign of the divisor.
      r = h % n;
      if (r < 0) r += n;
      i = int'(r) + 1;
      if (i >= hsa_pkg::SLOTS || busy_mark[i]) return res;
    end else begin
      i = 0;
      while (i < cnt && busy_mark[i]) i++;
      if (i >= cnt) return res;
    end
    busy_mark[i]   = 1'b1;
    res.granted    = 1'b1;
    res.slot_index = i[hsa_pkg::SLOT_W-1:0];
    return res;
  endfunction

  function automatic int unsigned rand_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic hsa_pkg::in_word_t pick_word(logic has_hint,
                                                  logic [hsa_pkg::HINT_W-1:0] hint);
    hsa_pkg::in_word_t w;
    w.op           = hsa_pkg::OP_PICK;
    w.has_hint     = has_hint;
    w.hint_value   = has_hint ? hint : hsa_pkg::HINT_W'($urandom);
    w.release_slot = hsa_pkg::SLOT_W'($urandom);
    return w;
  endfunction

  function automatic hsa_pkg::in_word_t release_word(logic [hsa_pkg::SLOT_W-1:0] slot);
    hsa_pkg::in_word_t w;
    w.op           = hsa_pkg::OP_RELEASE;
    w.has_hint     = 1'($urandom);
    w.hint_value   = hsa_pkg::HINT_W'($urandom);
    w.release_slot = slot;
    return w;
  endfunction

  // Offers one word after an optional idle gap and waits until it is taken.
  task automatic send_word(hsa_pkg::in_word_t w, int unsigned gap);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (!in_ready);
    owed_results.push_back(allocate_or_free(w));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_pool_count(logic [hsa_pkg::COUNT_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    pool_count = value;
  endtask

  task automatic test_first_fit();
    repeat (3) send_word(pick_word(1'b0, '0), rand_gap());
    send_word(release_word(6'd1), rand_gap());
    send_word(pick_word(1'b0, '0), rand_gap());
    // Releasing a slot that is already free still reports it.
    send_word(release_word(6'd10), rand_gap());
    send_word(release_word(6'd63), rand_gap());
    drain_results();
  endtask

  task automatic test_hint_mapping();
    // Slot 1 is busy from the first-fit test, so a zero hint is refused.
    send_word(pick_word(1'b1, 32'd0), rand_gap());
    send_word(pick_word(1'b1, 32'hFFFF_FFFF), rand_gap());
    send_word(pick_word(1'b1, 32'h7FFF_FFFF), rand_gap());
    send_word(pick_word(1'b1, 32'h8000_0000), rand_gap());
    send_word(pick_word(1'b1, 32'd62), rand_gap());
    send_word(pick_word(1'b1, 32'hFFFF_FFC1), rand_gap());
    drain_results();
  endtask

  task automatic test_count_limits();
    set_pool_count(7'd2);
    send_word(pick_word(1'b1, 32'h1234_5678), rand_gap());
    send_word(pick_word(1'b0, '0), rand_gap());
    send_word(release_word(6'd2), rand_gap());
    send_word(release_word(6'd1), rand_gap());
    set_pool_count(7'd0);
    send_word(pick_word(1'b1, 32'h8000_0000), rand_gap());
    set_pool_count(7'd1);
    send_word(pick_word(1'b0, '0), rand_gap());
    send_word(release_word(6'd0), rand_gap());
    // Slot 63 stays busy while out of reach and is seen again at full size.
    set_pool_count(7'd127);
    send_word(pick_word(1'b1, 32'hFFFF_FFFF), rand_gap());
    set_pool_count(7'd64);
    send_word(release_word(6'd63), rand_gap());
    drain_results();
  endtask

  task automatic test_backpressure();
    calm = 1'b1;
    @(posedge clk_i);
    hold_off_cycles = HOLD_CYCLES;
    repeat (8) send_word(pick_word(1'($urandom), hsa_pkg::HINT_W'($urandom)), 0);
    calm = 1'b0;
    drain_results();
  endtask

  task automatic test_random_traffic();
    logic [hsa_pkg::COUNT_W-1:0] counts [8];
    int unsigned                 sel;
    int unsigned                 cnt;
    int unsigned                 start;
    int unsigned                 s;
    logic [hsa_pkg::HINT_W-1:0]  hint;
    logic [hsa_pkg::SLOT_W-1:0]  slot;
    hsa_pkg::in_word_t           w;
    counts = '{7'd3, 7'd5, 7'd2, 7'd9, 7'd17, 7'd64, 7'd33, 7'd127};
    for (int p = 0; p < 8; p++) begin
      if (p == 7) set_pool_count(hsa_pkg::COUNT_W'($urandom_range(0, 127)));
      else set_pool_count(counts[p]);
      for (int k = 0; k < 82; k++) begin
        if (k % 20 == 0) calm = ($urandom_range(0, 3) == 0);
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          sel = $urandom_range(0, 99);
          if (sel < 60) hint = hsa_pkg::HINT_W'(int'($urandom_range(0, 200)) - 100);
          else if (sel < 90) hint = hsa_pkg::HINT_W'($urandom);
          else begin
            case ($urandom_range(0, 3))
              0: hint = 32'h7FFF_FFFF;
              1: hint = 32'h8000_0000;
              2: hint = 32'd0;
              default: hint = 32'hFFFF_FFFF;
            endcase
          end
          w = pick_word(($urandom_range(0, 99) < 40), hint);
        end else begin
          // Mostly free a slot that is held, sometimes any index at all.
          slot = hsa_pkg::SLOT_W'($urandom);
          if ($urandom_range(0, 99) < 70) begin
            cnt   = effective_count();
            start = $urandom_range(0, cnt - 1);
            for (int j = 0; j < cnt; j++) begin
              s = (start + j) % cnt;
              if (busy_mark[s]) begin
                slot = s[hsa_pkg::SLOT_W-1:0];
                break;
              end
            end
          end
          w = release_word(slot);
        end
        send_word(w, rand_gap());
      end
    end
    calm = 1'b0;
    drain_results();
  endtask

  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
      hold_off_cycles--;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 25) stall_left = rand_gap();
    end
  end

  always @(posedge clk_i) begin
    hsa_pkg::out_word_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        $error("result word %0h arrived with none expected", out_data);
        error_count++;
      end else begin
        want = owed_results.pop_front();
        if (out_data.granted !== want.granted) begin
          $error("granted: expected %0d, actual %0d", want.granted, out_data.granted);
          error_count++;
        end
        if (out_data.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, actual %0d", want.slot_index,
                 out_data.slot_index);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("hinted_slot_allocator_core_test: done, errors");
      $finish;
    end
  end

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_ready       = 1'b0;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    cycle_count     = 0;
    error_count     = 0;
    hold_off_cycles = 0;
    stall_left      = 0;
    calm            = 1'b0;
    pool_count      = hsa_pkg::COUNT_RESET;
    for (int j = 0; j < hsa_pkg::SLOTS; j++) busy_mark[j] = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_first_fit();
    test_hint_mapping();
    test_count_limits();
    test_backpressure();
    test_random_traffic();

    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("hinted_slot_allocator_core_test: done, clean");
    end else begin
      $display("hinted_slot_allocator_core_test: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/hsa_pkg.sv
rtl/hsa_mod_unit.sv
rtl/hsa_busy_map.sv
rtl/hinted_slot_allocator_core.sv
verif/hinted_slot_allocator_core_test.sv
